// File: rtl/dpia_pkg.sv
// ---------------------------------------------------------------------------
// dpia_pkg
// Widths, constants and pipeline depth of the integer dew point estimator.
// ---------------------------------------------------------------------------
package dpia_pkg;

  // transaction field widths
  localparam int HUM_W  = 8;
  localparam int TEMP_W = 12;
  localparam int DEW_W  = 12;

  // Magnus approximation constants
  localparam int LOG_NUM = 980;    // numerator of the coarse log term
  localparam int LOG_MAX = 200;    // clamp on the log estimate
  localparam int LOG_OFS = 20000;  // offset on 100 * log estimate
  localparam int LOG_DIV = 43;     // divisor of the humidity term
  localparam int MAG_A   = 881;    // temperature term numerator factor
  localparam int MAG_B   = 243;    // temperature term divisor offset
  localparam int MAG_D   = 1762;   // final divisor offset
  localparam int MAG_N   = 24310;  // final dividend
  localparam int RND_OFS = 51;     // rounding offset before the last divide

  // divide-by-ten reciprocals (multiply then shift)
  localparam int R10_T_MUL = 6554;   // exact for magnitudes up to 2048
  localparam int R10_T_SH  = 16;
  localparam int R10_Q_MUL = 52429;  // exact for magnitudes up to 32767
  localparam int R10_Q_SH  = 19;

  // largest magnitude of the temperature in whole degrees
  localparam int A_MAX = 204;

  // internal widths
  localparam int K1_W   = 10;  // humidity term, -465..0
  localparam int TP_W   = 10;  // positive temperature term, 0..804
  localparam int TN_W   = 14;  // negative temperature term magnitude, 0..9216
  localparam int AMAG_W = 8;   // whole degree magnitude, 0..204
  localparam int K_W    = 15;  // combined term, -9681..804
  localparam int D_W    = 14;  // final divisor, 958..11443
  localparam int QT_W   = 5;   // final quotient, 0..25
  localparam int REM_W  = 15;  // divider remainder
  localparam int Q_W    = 16;  // scaled dew point, about +/-20100

  // register stages from input to output
  localparam int NSTG = 7;

  typedef logic [HUM_W-1:0]         hum_t;
  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic signed [DEW_W-1:0]  dew_t;

endpackage

// File: rtl/dpia_if.sv
// ---------------------------------------------------------------------------
// dpia_in_if / dpia_out_if
// Valid/ready channels carrying sensor readings in and dew points out.
// ---------------------------------------------------------------------------
interface dpia_in_if;
  import dpia_pkg::*;

  logic  valid;
  logic  ready;
  hum_t  humidity_pct;
  temp_t temp_tenths;

  modport source (output valid, humidity_pct, temp_tenths, input ready);
  modport sink   (input valid, humidity_pct, temp_tenths, output ready);
endinterface

interface dpia_out_if;
  import dpia_pkg::*;

  logic valid;
  logic ready;
  dew_t dew_point_tenths;

  modport source (output valid, dew_point_tenths, input ready);
  modport sink   (input valid, dew_point_tenths, output ready);
endinterface

// File: rtl/dew_point_integer_approx_top.sv
// ---------------------------------------------------------------------------
// dew_point_integer_approx_top
// Integer Magnus dew point estimate from humidity (%) and temperature (0.1C).
// ---------------------------------------------------------------------------
//  channel   direction  payload                         handshake
//  in_chan   sink       humidity_pct, temp_tenths       valid / ready
//  out_chan  source     dew_point_tenths                valid / ready
//
//  Seven register stages; one transaction accepted per cycle while out_chan
//  is not stalled. The result is driven from the stage 7 register. The rate
//  is set by the stage chain, each stage holding one transaction.
//  Reset (rst_n low, synchronous) clears the stage valid bits only.
//  Each stage advances when it is empty or the next one moves, so a stall on
//  out_chan fills bubbles first and then holds in_chan.ready low.
// ---------------------------------------------------------------------------
module dew_point_integer_approx_top (
  input  logic        clk,
  input  logic        rst_n,
  dpia_in_if.sink     in_chan,
  dpia_out_if.source  out_chan
);
  import dpia_pkg::*;

  // constant tables, built at elaboration
  logic signed [K1_W-1:0] k1_tab  [256];
  logic [TP_W-1:0]        tp_tab  [256];
  logic [TN_W-1:0]        tn_tab  [256];

  // stage control
  logic [NSTG:1] vld_r;
  logic [NSTG:1] vld_src;
  logic [NSTG:1] st_en;

  // stage 1: humidity term, temperature magnitude
  logic signed [K1_W-1:0] s1_k1_r, s1_k1_nxt;
  logic [TEMP_W-1:0]      s1_tmag_r, s1_tmag_nxt;
  logic                   s1_tneg_r, s1_tneg_nxt;
  // stage 2: whole degrees
  logic signed [K1_W-1:0] s2_k1_r;
  logic [AMAG_W-1:0]      s2_amag_r, s2_amag_nxt;
  logic                   s2_aneg_r;
  logic [TEMP_W+13-1:0]   s2_prod;
  // stage 3: combined term and final divisor
  logic signed [K_W-1:0]  s3_k_r, s3_k_nxt;
  logic [D_W-1:0]         s3_d_r, s3_d_nxt;
  logic signed [K_W-1:0]  s3_term;
  logic signed [K_W:0]    s3_dfull;
  // stage 4: upper quotient bits
  logic signed [K_W-1:0]  s4_k_r;
  logic [D_W-1:0]         s4_d_r;
  logic [REM_W-1:0]       s4_rem_r, s4_rem_nxt;
  logic [QT_W-1:0]        s4_quo_r, s4_quo_nxt;
  // stage 5: lower quotient bits
  logic signed [K_W-1:0]  s5_k_r;
  logic [QT_W-1:0]        s5_quo_r, s5_quo_nxt;
  // stage 6: product
  logic signed [Q_W-1:0]  s6_q_r, s6_q_nxt;
  logic [19:0]            s6_prod;
  // stage 7: rounding and divide by ten
  dew_t                   s7_res_r, s7_res_nxt;
  logic [Q_W-1:0]         s7_qmag;
  logic [Q_W-1:0]         s7_qrnd;
  logic [Q_W+16-1:0]      s7_prod;
  logic [DEW_W-1:0]       s7_rmag;

  // humidity table: (100 * clamped log estimate - 20000) / 43
  for (genvar g = 0; g < 256; g++) begin : g_k1_tab
    localparam int HDIV   = (g == 0) ? 1 : g;
    localparam int LE_BAS = (LOG_NUM - LOG_NUM / HDIV) / 10;
    localparam int LE_RNG = (g < 31) ? (19 * g) / 10 - 4 :
                            (g > 51 && g < 81) ? (67 * g) / 100 + 42 :
                            (67 * g) / 100 + 39;
    localparam int LE_RAW = (g == 1) ? 0 : (g < 8) ? 11 * g + 11 : LE_BAS + LE_RNG;
    localparam int LE     = (LE_RAW > LOG_MAX) ? LOG_MAX : LE_RAW;
    localparam int K1     = (100 * LE - LOG_OFS) / LOG_DIV;
    assign k1_tab[g] = K1_W'(K1);
  end

  // temperature tables: 2 * (881 * a) / (243 + a), by sign of a
  for (genvar m = 0; m < 256; m++) begin : g_term_tab
    localparam int MV     = (m <= A_MAX) ? m : 0;
    localparam int TDIV_P = MAG_B + MV;
    localparam int TDIV_N = MAG_B - MV;
    localparam int TP     = 2 * ((MAG_A * MV) / TDIV_P);
    localparam int TN     = 2 * ((MAG_A * MV) / TDIV_N);
    assign tp_tab[m] = TP_W'(TP);
    assign tn_tab[m] = TN_W'(TN);
  end

  // stage enables: a stage moves when empty or when its successor moves
  always_comb begin
    st_en[NSTG] = !vld_r[NSTG] || out_chan.ready;
    for (int i = NSTG - 1; i >= 1; i--) begin
      st_en[i] = !vld_r[i] || st_en[i+1];
    end
  end

  assign vld_src        = {vld_r[NSTG-1:1], in_chan.valid};
  assign in_chan.ready  = st_en[1];
  assign out_chan.valid = vld_r[NSTG];
  assign out_chan.dew_point_tenths = s7_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int i = 1; i <= NSTG; i++) begin
        if (st_en[i]) begin
          vld_r[i] <= vld_src[i];
        end
      end
    end
  end

  // stage 1
  always_comb begin
    s1_k1_nxt   = k1_tab[in_chan.humidity_pct];
    s1_tneg_nxt = in_chan.temp_tenths[TEMP_W-1];
    s1_tmag_nxt = s1_tneg_nxt ? TEMP_W'(-in_chan.temp_tenths)
                              : TEMP_W'(in_chan.temp_tenths);
  end

  // stage 2: |t| / 10 by reciprocal
  always_comb begin
    s2_prod     = (TEMP_W+13)'(s1_tmag_r) * (TEMP_W+13)'(R10_T_MUL);
    s2_amag_nxt = s2_prod[R10_T_SH +: AMAG_W];
  end

  // stage 3: add temperature term, form divisor
  always_comb begin
    s3_term  = s2_aneg_r ? -K_W'(signed'({1'b0, tn_tab[s2_amag_r]}))
                         : K_W'(signed'({1'b0, tp_tab[s2_amag_r]}));
    s3_k_nxt = K_W'(s2_k1_r) + s3_term;
    s3_dfull = (K_W+1)'(MAG_D) - (K_W+1)'(s3_k_nxt);
    s3_d_nxt = s3_dfull[D_W-1:0];
  end

  // stage 4: restoring divide, quotient bits 4..2
  always_comb begin
    logic [REM_W+4-1:0] rem;
    logic [REM_W+4-1:0] dsh;
    rem        = (REM_W+4)'(MAG_N);
    s4_quo_nxt = '0;
    for (int i = QT_W - 1; i >= 2; i--) begin
      dsh = (REM_W+4)'(s3_d_r) << i;
      if (rem >= dsh) begin
        rem           = rem - dsh;
        s4_quo_nxt[i] = 1'b1;
      end
    end
    s4_rem_nxt = rem[REM_W-1:0];
  end

  // stage 5: quotient bits 1..0
  always_comb begin
    logic [REM_W+1-1:0] rem;
    logic [REM_W+1-1:0] dsh;
    rem        = (REM_W+1)'(s4_rem_r);
    s5_quo_nxt = s4_quo_r;
    for (int i = 1; i >= 0; i--) begin
      dsh = (REM_W+1)'(s4_d_r) << i;
      if (rem >= dsh) begin
        rem           = rem - dsh;
        s5_quo_nxt[i] = 1'b1;
      end
    end
  end

  // stage 6: quotient times combined term
  always_comb begin
    s6_prod  = 20'(s5_k_r) * 20'(s5_quo_r);
    s6_q_nxt = signed'(s6_prod[Q_W-1:0]);
  end

  // stage 7: round away from zero, divide by ten
  always_comb begin
    s7_qmag    = s6_q_r[Q_W-1] ? Q_W'(-s6_q_r) : Q_W'(s6_q_r);
    s7_qrnd    = s7_qmag + Q_W'(RND_OFS);
    s7_prod    = (Q_W+16)'(s7_qrnd) * (Q_W+16)'(R10_Q_MUL);
    s7_rmag    = s7_prod[R10_Q_SH +: DEW_W];
    s7_res_nxt = s6_q_r[Q_W-1] ? dew_t'(-s7_rmag) : dew_t'(s7_rmag);
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (st_en[1]) begin
      s1_k1_r   <= s1_k1_nxt;
      s1_tmag_r <= s1_tmag_nxt;
      s1_tneg_r <= s1_tneg_nxt;
    end
    if (st_en[2]) begin
      s2_k1_r   <= s1_k1_r;
      s2_amag_r <= s2_amag_nxt;
      s2_aneg_r <= s1_tneg_r;
    end
    if (st_en[3]) begin
      s3_k_r <= s3_k_nxt;
      s3_d_r <= s3_d_nxt;
    end
    if (st_en[4]) begin
      s4_k_r   <= s3_k_r;
      s4_d_r   <= s3_d_r;
      s4_rem_r <= s4_rem_nxt;
      s4_quo_r <= s4_quo_nxt;
    end
    if (st_en[5]) begin
      s5_k_r   <= s4_k_r;
      s5_quo_r <= s5_quo_nxt;
    end
    if (st_en[6]) begin
      s6_q_r <= s6_q_nxt;
    end
    if (st_en[7]) begin
      s7_res_r <= s7_res_nxt;
    end
  end

`ifndef SYNTH
  // occupancy grows by one on an input transaction without an output one
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && !(out_chan.valid && out_chan.ready))
    |=> $countones(vld_r) == $past($countones(vld_r)) + 1)
    else $error("pipeline occupancy did not grow on input transaction");

  // whole degree magnitude stays within the table range
  a_amag_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> s2_amag_r <= AMAG_W'(A_MAX))
    else $error("temperature magnitude out of table range");

  // final divisor never drops below its bound
  a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[3] |-> s3_d_r >= D_W'(958))
    else $error("final divisor below bound");

  // a full pipeline whose output is not taken holds in_chan.ready low
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (&vld_r && !out_chan.ready) |-> !in_chan.ready)
    else $error("full pipeline accepted while stalled");
`endif

endmodule
